### design/vsr_pkg.sv
`default_nettype none
package vsr_pkg;

   localparam int QBITS = 16;
   localparam logic [14:0] SPEED_RESET = 15'd256;
   localparam logic [15:0] POS_MAX = 16'd32767;
   localparam logic [15:0] NEG_MAX = 16'd32768;

   // one component on its way through the root chain
   typedef struct packed {
      logic        neg;
      logic [63:0] res;   // rhs minus q^2 * msq
      logic [47:0] prod;  // q * msq
      logic [15:0] q;
   } vsr_lane_type;

   typedef struct packed {
      logic         valid;
      logic         zero;
      logic [31:0]  msq;
      vsr_lane_type lx;
      vsr_lane_type ly;
   } vsr_stage_type;

   // try one result bit: (2^(b+1) q + 2^(2b)) msq <= res
   function automatic vsr_lane_type lane_step(vsr_lane_type lane, logic [31:0] msq, int b);
      logic [65:0] trial;
      vsr_lane_type nxt;
      trial = ({18'd0, lane.prod} << (b + 1)) + ({34'd0, msq} << (2 * b));
      nxt = lane;
      if (trial <= {2'd0, lane.res}) begin
         nxt.res  = lane.res - trial[63:0];
         nxt.prod = lane.prod + ({16'd0, msq} << b);
         nxt.q    = lane.q | (16'd1 << b);
      end
      return nxt;
   endfunction

endpackage
`default_nettype wire

### design/vsr_if.sv
`default_nettype none
interface vsr_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   modport source (output valid, output vel_x, output vel_y, input ready);
   modport sink (input valid, input vel_x, input vel_y, output ready);
endinterface

interface vsr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic               was_zero;
   modport source (output valid, output out_x, output out_y, output was_zero, input ready);
   modport sink (input valid, input out_x, input out_y, input was_zero, output ready);
endinterface
`default_nettype wire

### design/vsr_cell.sv
`default_nettype none
module vsr_cell
   import vsr_pkg::*;
#(
   parameter int BIT = 15
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  vsr_stage_type stage_in,
   output vsr_stage_type stage_out
);

   vsr_stage_type stage_ff, stage_in_nxt;

   // decide one result bit for both components
   always_comb begin
      stage_in_nxt    = stage_in;
      stage_in_nxt.lx = lane_step(stage_in.lx, stage_in.msq, BIT);
      stage_in_nxt.ly = lane_step(stage_in.ly, stage_in.msq, BIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_nxt.valid;
      end
      if (advance) begin
         stage_ff.zero <= stage_in_nxt.zero;
         stage_ff.msq  <= stage_in_nxt.msq;
         stage_ff.lx   <= stage_in_nxt.lx;
         stage_ff.ly   <= stage_in_nxt.ly;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

### design/vector_speed_rescale_unit.sv
`default_nettype none
// pipeline: 2 front stages, 16 root cells and the output register from item accept to result valid
// throughput: one item per cycle unless held; each cell of the root chain decides one result bit
// the whole pipeline holds while a result waits at the output
// reset (synchronous) empties the pipeline and sets target speed to 1.0
module vector_speed_rescale_unit
   import vsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   vsr_req_if.sink          req_if,
   vsr_rsp_if.source        rsp_if,
   input  wire logic        csr_we,
   input  wire logic [14:0] csr_wdata
);

   logic [14:0] speed_ff;
   logic        advance;

   logic        a_valid_ff, a_negx_ff, a_negy_ff;
   logic [31:0] a_sqx_ff, a_sqy_ff;
   logic [30:0] a_nx_ff, a_ny_ff;
   logic [15:0] mx, my;

   vsr_stage_type b_stage_ff;
   vsr_stage_type chain [QBITS+1];

   logic               o_valid_ff, o_zero_ff;
   logic signed [15:0] o_x_ff, o_y_ff;

   assign advance      = !o_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // speed register
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SPEED_RESET;
      end else if (csr_we) begin
         speed_ff <= csr_wdata;
      end
   end

   // magnitudes, squares and scaled magnitudes
   assign mx = req_if.vel_x[15] ? 16'(-req_if.vel_x) : req_if.vel_x;
   assign my = req_if.vel_y[15] ? 16'(-req_if.vel_y) : req_if.vel_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_if.valid;
      end
      if (advance) begin
         a_negx_ff  <= req_if.vel_x[15];
         a_negy_ff  <= req_if.vel_y[15];
         a_sqx_ff   <= mx * mx;
         a_sqy_ff   <= my * my;
         a_nx_ff    <= 31'(mx) * 31'(speed_ff);
         a_ny_ff    <= 31'(my) * 31'(speed_ff);
      end
   end

   // length squared and squared numerators
   always_ff @(posedge clock) begin
      if (reset) begin
         b_stage_ff.valid <= 1'b0;
      end else if (advance) begin
         b_stage_ff.valid <= a_valid_ff;
      end
      if (advance) begin
         b_stage_ff.msq     <= a_sqx_ff + a_sqy_ff;
         b_stage_ff.zero    <= (a_sqx_ff == 32'd0) && (a_sqy_ff == 32'd0);
         b_stage_ff.lx.neg  <= a_negx_ff;
         b_stage_ff.lx.res  <= 64'(a_nx_ff) * 64'(a_nx_ff);
         b_stage_ff.lx.prod <= '0;
         b_stage_ff.lx.q    <= '0;
         b_stage_ff.ly.neg  <= a_negy_ff;
         b_stage_ff.ly.res  <= 64'(a_ny_ff) * 64'(a_ny_ff);
         b_stage_ff.ly.prod <= '0;
         b_stage_ff.ly.q    <= '0;
      end
   end

   assign chain[0] = b_stage_ff;

   // root chain, most significant bit first
   for (genvar k = 0; k < QBITS; k++) begin : g_cell
      vsr_cell #(.BIT(QBITS - 1 - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[k]),
         .stage_out (chain[k+1])
      );
   end

   function automatic logic [15:0] apply_sign(vsr_lane_type lane);
      logic [15:0] q;
      if (lane.neg) begin
         q = (lane.q > NEG_MAX) ? NEG_MAX : lane.q;
         return 16'(-q);
      end
      q = (lane.q > POS_MAX) ? POS_MAX : lane.q;
      return q;
   endfunction

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         o_valid_ff <= chain[QBITS].valid;
      end
      if (advance) begin
         o_zero_ff  <= chain[QBITS].zero;
         o_x_ff     <= chain[QBITS].zero ? 16'sd0 : apply_sign(chain[QBITS].lx);
         o_y_ff     <= chain[QBITS].zero ? 16'sd0 : apply_sign(chain[QBITS].ly);
      end
   end

   assign rsp_if.valid    = o_valid_ff;
   assign rsp_if.out_x    = o_x_ff;
   assign rsp_if.out_y    = o_y_ff;
   assign rsp_if.was_zero = o_zero_ff;

endmodule
`default_nettype wire
